// ===== hw/rtl/clipped_histogram_equalizer_assert.svh =====
// Assertion helpers for the histogram equalizer.
`ifndef CLIPPED_HISTOGRAM_EQUALIZER_ASSERT_SVH
`define CLIPPED_HISTOGRAM_EQUALIZER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CLHE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CLHE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/clhe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package clhe_pkg;

  localparam int unsigned CountW  = 23;

  localparam logic [CountW-1:0] MaxPixels = 23'd4194304;
  localparam logic [7:0]        ClipReset = 8'd205;
  localparam logic [7:0]        PixMax    = 8'd255;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_ACC,
    ST_MAP,
    ST_PEAK,
    ST_LEVEL,
    ST_EXC,
    ST_RD,
    ST_ADD,
    ST_SCALE,
    ST_CMP
  } state_e;

endpackage
`default_nettype wire

// ===== hw/rtl/clipped_histogram_equalizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Accumulate transfer: bin read, then write back; map transfer: result strobed in the
// cycle after accept, next item accepted once busy drops after the previous one.
// A last accumulate item starts the table build, made of three 256-entry sweeps of the
// bin RAM plus up to 255 rank-increment steps.
// After reset the bin RAM is zeroed with busy high; results cannot stall.
module clipped_histogram_equalizer (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start,
  output logic              busy,
  input  wire               kind_i,
  input  wire  [7:0]        pixel_i,
  input  wire               last_i,
  input  wire               clip_fraction_we_i,
  input  wire  [7:0]        clip_fraction_i,
  output logic              result_valid_o,
  output logic [7:0]        mapped_pixel_o,
  output logic              last_out_o
);
  import clhe_pkg::*;

  logic [22:0] bin_mem [256];
  logic [7:0]  map_mem [256];

  state_e      state_q, state_d;
  logic [8:0]  cnt_q, cnt_d;
  logic [22:0] total_q, total_d;
  logic [7:0]  clip_q;
  logic [7:0]  pix_q, pix_d;
  logic        last_q, last_d;
  logic        built_q, built_d;
  logic [22:0] peak_q, peak_d;
  logic [38:0] level_q, level_d;
  logic [38:0] excess_q, excess_d;
  logic [39:0] cum_q, cum_d;
  logic [47:0] lhs_q, lhs_d;
  logic [47:0] thresh_q, thresh_d;
  logic [7:0]  m_q, m_d;

  logic [22:0] bin_rd_q;
  logic [7:0]  map_rd_q;
  logic [7:0]  bin_raddr, bin_waddr;
  logic        bin_we, map_we, map_re;
  logic [22:0] bin_wdata;
  logic [7:0]  map_wdata;

  logic [38:0] bin_b, clipped;
  logic [31:0] prod;
  logic [47:0] denom;

  assign bin_b   = {bin_rd_q, 16'b0};
  assign clipped = (bin_b > level_q) ? level_q : bin_b;
  assign prod    = {9'b0, peak_q} * {23'b0, 9'd256 - {1'b0, clip_q}};
  assign denom   = {9'b0, total_q, 16'b0};

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    total_d   = total_q;
    pix_d     = pix_q;
    last_d    = last_q;
    built_d   = built_q;
    peak_d    = peak_q;
    level_d   = level_q;
    excess_d  = excess_q;
    cum_d     = cum_q;
    lhs_d     = lhs_q;
    thresh_d  = thresh_q;
    m_d       = m_q;
    bin_raddr = cnt_q[7:0];
    bin_waddr = cnt_q[7:0];
    bin_we    = 1'b0;
    bin_wdata = '0;
    map_we    = 1'b0;
    map_wdata = '0;
    map_re    = 1'b0;
    case (state_q)
      ST_CLR: begin
        bin_we = 1'b1;
        cnt_d  = cnt_q + 9'd1;
        if (cnt_q[7:0] == 8'hFF) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        bin_raddr = pixel_i;
        map_re    = 1'b1;
        if (start) begin
          pix_d   = pixel_i;
          last_d  = last_i;
          state_d = kind_i ? ST_MAP : ST_ACC;
        end
      end
      ST_ACC: begin
        bin_waddr = pix_q;
        if (total_q < MaxPixels) begin
          bin_we    = 1'b1;
          bin_wdata = bin_rd_q + 23'd1;
          total_d   = total_q + 23'd1;
        end
        if (last_q) begin
          cnt_d   = '0;
          peak_d  = '0;
          state_d = ST_PEAK;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MAP: begin
        state_d = ST_IDLE;
      end
      // Read data comes in the cycle after its address, so a sweep ends one count past the last entry.
      ST_PEAK: begin
        cnt_d = cnt_q + 9'd1;
        if (cnt_q != 9'd0 && bin_rd_q > peak_q) begin
          peak_d = bin_rd_q;
        end
        if (cnt_q[8]) begin
          state_d = ST_LEVEL;
        end
      end
      ST_LEVEL: begin
        level_d  = {prod[30:0], 8'b0};
        excess_d = '0;
        cnt_d    = '0;
        state_d  = ST_EXC;
      end
      ST_EXC: begin
        cnt_d = cnt_q + 9'd1;
        if (cnt_q != 9'd0 && bin_b > level_q) begin
          excess_d = excess_q + (bin_b - level_q);
        end
        if (cnt_q[8]) begin
          cnt_d    = '0;
          cum_d    = '0;
          m_d      = '0;
          thresh_d = denom;
          state_d  = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_ADD;
      end
      ST_ADD: begin
        cum_d   = cum_q + {1'b0, clipped} + {9'b0, excess_q[38:8]};
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        lhs_d   = ({cum_q, 8'b0} - {8'b0, cum_q}) + {10'b0, total_q, 15'b0};
        state_d = ST_CMP;
      end
      // The map value only grows along the cumulative sum, so the quotient is
      // found by stepping the rank up one threshold at a time.
      ST_CMP: begin
        if (total_q != '0 && m_q != PixMax && lhs_q >= thresh_q) begin
          m_d      = m_q + 8'd1;
          thresh_d = thresh_q + denom;
        end else begin
          map_we    = 1'b1;
          map_wdata = (total_q == '0) ? 8'd0 : m_q;
          bin_we    = 1'b1;
          cnt_d     = cnt_q + 9'd1;
          if (cnt_q[7:0] == 8'hFF) begin
            cnt_d   = '0;
            total_d = '0;
            built_d = 1'b1;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      cnt_q   <= '0;
      total_q <= '0;
      clip_q  <= ClipReset;
      last_q  <= 1'b0;
      built_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
      last_q  <= last_d;
      built_q <= built_d;
      if (clip_fraction_we_i) begin
        clip_q <= clip_fraction_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q    <= pix_d;
    peak_q   <= peak_d;
    level_q  <= level_d;
    excess_q <= excess_d;
    cum_q    <= cum_d;
    lhs_q    <= lhs_d;
    thresh_q <= thresh_d;
    m_q      <= m_d;
  end

  always_ff @(posedge clk_i) begin
    bin_rd_q <= bin_mem[bin_raddr];
    if (bin_we) begin
      bin_mem[bin_waddr] <= bin_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_re) begin
      map_rd_q <= map_mem[pixel_i];
    end
    if (map_we) begin
      map_mem[cnt_q[7:0]] <= map_wdata;
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = (state_q == ST_MAP);
  assign mapped_pixel_o = built_q ? map_rd_q : 8'd0;
  assign last_out_o     = last_q;

`include "clipped_histogram_equalizer_assert.svh"

  `CLHE_ASSERT_NEXT(a_map_result, start && !busy && kind_i, result_valid_o, "no map result")
  `CLHE_ASSERT_NEXT(a_acc_silent, start && !busy && !kind_i, !result_valid_o, "acc result")
  `CLHE_ASSERT_NOW(a_total_bound, 1'b1, total_q <= MaxPixels, "pixel count above limit")

endmodule
`default_nettype wire
